### sv/tfd_pkg.sv
// Shared constants, register indexes and helpers for the three-tap feedback delay.
`timescale 1ns / 1ps

package tfd_pkg;

   localparam int MAX_DELAY_DEF   = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DELAY_W     = 16;
   localparam int FB_W        = 15;
   localparam int GAIN_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_CENTRE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_GAIN     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DRY_GAIN     = 3'd5;

   localparam logic [DELAY_W-1:0] DELAY_LEFT_RST   = 16'd14400;
   localparam logic [DELAY_W-1:0] DELAY_CENTRE_RST = 16'd38400;
   localparam logic [DELAY_W-1:0] DELAY_RIGHT_RST  = 16'd22560;
   localparam logic [FB_W-1:0]    FEEDBACK_RST     = 15'd9830;
   localparam logic [GAIN_W-1:0]  WET_GAIN_RST     = 16'd11469;
   localparam logic [GAIN_W-1:0]  DRY_GAIN_RST     = 16'd32768;

   localparam logic [FB_W-1:0]   FB_MAX  = 15'd31130;
   localparam logic [GAIN_W-1:0] MIX_MAX = 16'd32768;

   // 0.7071 in Q1.15
   localparam int CENTRE_GAIN = 23170;

   typedef logic [GAIN_W-1:0] gain_type;

   function automatic int clamp_delay(input int d, input int max_delay);
      return (d >= max_delay) ? max_delay - 1 : d;
   endfunction

endpackage

### sv/three_tap_feedback_delay.sv
// Top level: tap sequencer, shared delay memory, tap feedback and register file.
//
//   channel   ports                                   direction  accept
//   req       req_valid/ready, req_sample_left/right  in         valid & ready
//   rsp       rsp_valid/ready, rsp_out_left/right     out        valid & ready
//   csr       csr_we, csr_index, csr_wdata            in         csr_we
//
// Throughput is set by the single memory port: three tap reads and one combined write
// per item. A new item can be accepted in the write step of the one before it.
// Reset needs no clearing pass: a wrap flag and the write pointer mark entries not
// yet written, which read as zero. A held result stalls the mixer, which in turn
// holds the sequencer in its write step; no further item is taken until it moves on.
`timescale 1ns / 1ps

module three_tap_feedback_delay #(
   parameter int MAX_DELAY   = tfd_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = tfd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_right,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_right,
   input  logic                                csr_we,
   input  logic [tfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tfd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tfd_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(MAX_DELAY);
   localparam int PW = SB + 16;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);
   localparam logic [AW-1:0] DL_RST = AW'(clamp_delay(int'(DELAY_LEFT_RST), MAX_DELAY));
   localparam logic [AW-1:0] DC_RST = AW'(clamp_delay(int'(DELAY_CENTRE_RST), MAX_DELAY));
   localparam logic [AW-1:0] DR_RST = AW'(clamp_delay(int'(DELAY_RIGHT_RST), MAX_DELAY));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDL  = 3'd1;
   localparam logic [2:0] ST_RDC  = 3'd2;
   localparam logic [2:0] ST_RDR  = 3'd3;
   localparam logic [2:0] ST_WR   = 3'd4;

   // register file
   logic [AW-1:0]   dly_l_ff, dly_c_ff, dly_r_ff;
   logic [FB_W-1:0] fb_ff;
   gain_type        wet_ff, dry_ff;
   logic [AW-1:0]   dly_wr;
   logic [FB_W-1:0] fb_wr;
   gain_type        gain_wr;

   // sequencer
   logic [2:0]      state_ff, state_in;
   logic            accept, mix_go, mix_free, wr_fire;
   logic [AW-1:0]   wp_ff;
   logic            wrapped_ff;

   // memory
   logic [3*SB-1:0] mem [MAX_DELAY];
   logic [3*SB-1:0] rdata_ff;
   logic            mem_re;
   logic [AW-1:0]   mem_ra, dly_sel;
   logic [AW:0]     diff;

   // datapath
   logic signed [SB-1:0] l_ff, r_ff;
   logic signed [SB:0]   sum_lr;
   logic signed [SB-1:0] mono;
   logic signed [15:0]   fbs;
   logic signed [PW-1:0] fbp_l_ff, fbp_c_ff, fbp_r_ff;
   logic signed [SB-1:0] tin_l_ff, tin_c_ff, tin_r_ff;
   logic signed [SB-1:0] raw_l_ff, raw_c_ff, raw_r;
   logic signed [SB-1:0] last_l_ff, last_c_ff, last_r_ff;
   logic signed [SB-1:0] tap_l, tap_c, tap_r;
   logic                 hit_l, hit_c, hit_r;

   function automatic logic signed [SB-1:0] sat_tap(input logic signed [SB+1:0] v);
      if ((v[SB+1:SB-1] == '0) || (v[SB+1:SB-1] == '1)) begin
         return v[SB-1:0];
      end else if (v[SB+1]) begin
         return {1'b1, {(SB-1){1'b0}}};
      end else begin
         return {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   // ---- register file ----
   assign dly_wr  = AW'(clamp_delay(int'(csr_wdata[DELAY_W-1:0]), MAX_DELAY));
   assign fb_wr   = (csr_wdata[FB_W-1:0] > FB_MAX) ? FB_MAX : csr_wdata[FB_W-1:0];
   assign gain_wr = (csr_wdata[GAIN_W-1:0] > MIX_MAX) ? MIX_MAX : csr_wdata[GAIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_l_ff <= DL_RST;
         dly_c_ff <= DC_RST;
         dly_r_ff <= DR_RST;
         fb_ff    <= FEEDBACK_RST;
         wet_ff   <= WET_GAIN_RST;
         dry_ff   <= DRY_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DELAY_LEFT:   dly_l_ff <= dly_wr;
            REG_DELAY_CENTRE: dly_c_ff <= dly_wr;
            REG_DELAY_RIGHT:  dly_r_ff <= dly_wr;
            REG_FEEDBACK:     fb_ff    <= fb_wr;
            REG_WET_GAIN:     wet_ff   <= gain_wr;
            REG_DRY_GAIN:     dry_ff   <= gain_wr;
            default: ;
         endcase
      end
   end

   // ---- sequencer ----
   assign mix_go    = (state_ff == ST_WR);
   assign wr_fire   = mix_go && mix_free;
   assign req_ready = (state_ff == ST_IDLE) || wr_fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RDL;
         ST_RDL:  state_in = ST_RDC;
         ST_RDC:  state_in = ST_RDR;
         ST_RDR:  state_in = ST_WR;
         ST_WR:   if (mix_free) state_in = accept ? ST_RDL : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         last_l_ff  <= '0;
         last_c_ff  <= '0;
         last_r_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_fire) begin
            wp_ff      <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
            wrapped_ff <= wrapped_ff || (wp_ff == LAST_ADDR);
            last_l_ff  <= tap_l;
            last_c_ff  <= tap_c;
            last_r_ff  <= tap_r;
         end
      end
   end

   // ---- delay memory: one lane per tap, one port ----
   always_comb begin
      case (state_ff)
         ST_RDC:  dly_sel = dly_c_ff;
         ST_RDR:  dly_sel = dly_r_ff;
         default: dly_sel = dly_l_ff;
      endcase
   end

   assign mem_re = (state_ff == ST_RDL) || (state_ff == ST_RDC) || (state_ff == ST_RDR);
   assign diff   = {1'b0, wp_ff} - {1'b0, dly_sel};
   assign mem_ra = diff[AW] ? AW'(diff + (AW+1)'(MAX_DELAY)) : diff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem[wp_ff] <= {tin_r_ff, tin_c_ff, tin_l_ff};
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   // ---- tap datapath ----
   assign sum_lr = (SB+1)'(l_ff) + (SB+1)'(r_ff);
   assign mono   = $signed(sum_lr[SB:1]);
   assign fbs    = $signed({1'b0, fb_ff});
   assign raw_r  = rdata_ff[3*SB-1:2*SB];

   always_ff @(posedge clock) begin
      if (accept) begin
         l_ff <= req_sample_left;
         r_ff <= req_sample_right;
      end
      fbp_l_ff <= PW'(last_l_ff) * PW'(fbs);
      fbp_c_ff <= PW'(last_c_ff) * PW'(fbs);
      fbp_r_ff <= PW'(last_r_ff) * PW'(fbs);
      if (state_ff == ST_RDC) begin
         raw_l_ff <= rdata_ff[SB-1:0];
         tin_l_ff <= sat_tap((SB+2)'(mono) + (SB+2)'($signed(fbp_l_ff[PW-1:15])));
         tin_c_ff <= sat_tap((SB+2)'(mono) + (SB+2)'($signed(fbp_c_ff[PW-1:15])));
         tin_r_ff <= sat_tap((SB+2)'(mono) + (SB+2)'($signed(fbp_r_ff[PW-1:15])));
      end
      if (state_ff == ST_RDR) begin
         raw_c_ff <= rdata_ff[2*SB-1:SB];
      end
   end

   // entries not yet written since reset read as zero; zero delay forwards the new value
   assign hit_l = wrapped_ff || (dly_l_ff <= wp_ff);
   assign hit_c = wrapped_ff || (dly_c_ff <= wp_ff);
   assign hit_r = wrapped_ff || (dly_r_ff <= wp_ff);

   assign tap_l = (dly_l_ff == '0) ? tin_l_ff : (hit_l ? raw_l_ff : '0);
   assign tap_c = (dly_c_ff == '0) ? tin_c_ff : (hit_c ? raw_c_ff : '0);
   assign tap_r = (dly_r_ff == '0) ? tin_r_ff : (hit_r ? raw_r : '0);

   tfd_mix #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock         (clock),
      .reset         (reset),
      .go            (mix_go),
      .free          (mix_free),
      .smp_l         (l_ff),
      .smp_r         (r_ff),
      .tap_l         (tap_l),
      .tap_c         (tap_c),
      .tap_r         (tap_r),
      .wet_gain      (wet_ff),
      .dry_gain      (dry_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right)
   );

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RDL)
      else $error("accepted item did not start tap reads");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      wr_fire |=> wp_ff == (($past(wp_ff) == LAST_ADDR) ? '0 : $past(wp_ff) + 1'b1))
      else $error("write pointer did not advance by one");

   a_wrap_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(wrapped_ff) |-> wp_ff == '0)
      else $error("wrap flag set away from pointer wrap");

   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      wr_fire && !accept |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle");

endmodule

### sv/tfd_mix.sv
// Wet/dry mixer: centre spread, gain products, shift and saturation, result register.
`timescale 1ns / 1ps

module tfd_mix #(
   parameter int SAMPLE_BITS = tfd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   output logic                          free,
   input  logic signed [SAMPLE_BITS-1:0] smp_l,
   input  logic signed [SAMPLE_BITS-1:0] smp_r,
   input  logic signed [SAMPLE_BITS-1:0] tap_l,
   input  logic signed [SAMPLE_BITS-1:0] tap_c,
   input  logic signed [SAMPLE_BITS-1:0] tap_r,
   input  tfd_pkg::gain_type             wet_gain,
   input  tfd_pkg::gain_type             dry_gain,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right
);
   import tfd_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int CW = SB + 16;
   localparam int MW = SB + 18;

   localparam logic [1:0] STEP_MUL  = 2'd0;
   localparam logic [1:0] STEP_WET  = 2'd1;
   localparam logic [1:0] STEP_WMUL = 2'd2;
   localparam logic [1:0] STEP_LAST = 2'd3;

   logic                 mbusy_ff;
   logic [1:0]           mstep_ff;
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] ml_ff, mr_ff, mtl_ff, mtc_ff, mtr_ff;
   logic signed [CW-1:0] cprod_ff;
   logic signed [MW-1:0] dl_ff, dr_ff, pl_ff, pr_ff;
   logic signed [SB:0]   wl_ff, wr_ff;
   logic signed [SB-1:0] out_l_ff, out_r_ff;

   logic signed [16:0]   wg, dg;
   logic signed [MW-1:0] mix_l, mix_r;
   logic                 slot_free, finish, take;

   function automatic logic signed [SB-1:0] sat_out(input logic signed [SB+2:0] v);
      if ((v[SB+2:SB-1] == '0) || (v[SB+2:SB-1] == '1)) begin
         return v[SB-1:0];
      end else if (v[SB+2]) begin
         return {1'b1, {(SB-1){1'b0}}};
      end else begin
         return {1'b0, {(SB-1){1'b1}}};
      end
   endfunction

   assign wg = $signed({1'b0, wet_gain});
   assign dg = $signed({1'b0, dry_gain});

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = mbusy_ff && (mstep_ff == STEP_LAST) && slot_free;
   assign free      = !mbusy_ff || finish;
   assign take      = go && free;

   assign mix_l = dl_ff + pl_ff;
   assign mix_r = dr_ff + pr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff     <= 1'b0;
         mstep_ff     <= STEP_MUL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            mbusy_ff <= 1'b1;
            mstep_ff <= STEP_MUL;
         end else if (finish) begin
            mbusy_ff <= 1'b0;
         end else if (mbusy_ff && (mstep_ff != STEP_LAST)) begin
            mstep_ff <= mstep_ff + 2'd1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ml_ff  <= smp_l;
         mr_ff  <= smp_r;
         mtl_ff <= tap_l;
         mtc_ff <= tap_c;
         mtr_ff <= tap_r;
      end
      if (mbusy_ff && (mstep_ff == STEP_MUL)) begin
         cprod_ff <= CW'(mtc_ff) * CW'(CENTRE_GAIN);
         dl_ff    <= MW'(ml_ff) * MW'(dg);
         dr_ff    <= MW'(mr_ff) * MW'(dg);
      end
      if (mbusy_ff && (mstep_ff == STEP_WET)) begin
         wl_ff <= (SB+1)'(mtl_ff) + $signed(cprod_ff[CW-1:15]);
         wr_ff <= (SB+1)'(mtr_ff) + $signed(cprod_ff[CW-1:15]);
      end
      if (mbusy_ff && (mstep_ff == STEP_WMUL)) begin
         pl_ff <= MW'(wl_ff) * MW'(wg);
         pr_ff <= MW'(wr_ff) * MW'(wg);
      end
      if (finish) begin
         out_l_ff <= sat_out($signed(mix_l[MW-1:15]));
         out_r_ff <= sat_out($signed(mix_r[MW-1:15]));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> mbusy_ff && (mstep_ff == STEP_MUL))
      else $error("mixer did not start on a new item");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      mbusy_ff && (mstep_ff != STEP_LAST) |=> mbusy_ff && (mstep_ff == $past(mstep_ff) + 2'd1))
      else $error("mixer step sequence broken");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule
